[src/pfrm_pkg.sv]
`timescale 1ns / 1ps

package pfrm_pkg;

    localparam int PAGE_COUNT   = 8;
    localparam int COLUMN_COUNT = 132;
    localparam int DEPTH        = PAGE_COUNT * COLUMN_COUNT;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int ROW_COUNT    = 8 * PAGE_COUNT;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] NIBBLE        = 8'h0F;
    localparam logic [7:0] FULL_MASK     = 8'hFF;
    localparam logic [2:0] OFFSET_RESET  = 3'd2;

    typedef enum logic [2:0] {
        OUT_BAD,
        OUT_CMD_LOW,
        OUT_CMD_HIGH,
        OUT_CMD_PAGE,
        OUT_DATA
    } t_out_sel;

    typedef struct packed {
        logic     clear;
        logic     capture;
        logic     open;
        logic     load;
        t_out_sel sel;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_hdr;
        logic hdr_bad;
        logic rect_active;
        logic first_col;
        logic out_free;
    } t_status;

endpackage

[src/pfrm_if.sv]
`timescale 1ns / 1ps

interface pfrm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rect_x_first;
    logic [7:0] rect_x_stop;
    logic [5:0] rect_y_first;
    logic [6:0] rect_y_stop;
    logic [7:0] pixel_byte;

    modport source (
        output valid, req_type, rect_x_first, rect_x_stop, rect_y_first, rect_y_stop,
               pixel_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, rect_x_first, rect_x_stop, rect_y_first, rect_y_stop,
               pixel_byte,
        output ready
    );
endinterface

interface pfrm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_of_page;
    logic       end_of_rect;
    logic       bad_rect;
    logic       last_of_item;

    modport source (
        output valid, out_byte, is_data, end_of_page, end_of_rect, bad_rect, last_of_item,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_data, end_of_page, end_of_rect, bad_rect, last_of_item,
        output ready
    );
endinterface

[src/pfrm_datapath.sv]
`timescale 1ns / 1ps

module pfrm_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata,
    input  logic              i_req_type,
    input  logic [7:0]        i_rect_x_first,
    input  logic [7:0]        i_rect_x_stop,
    input  logic [5:0]        i_rect_y_first,
    input  logic [6:0]        i_rect_y_stop,
    input  logic [7:0]        i_pixel_byte,
    input  pfrm_pkg::t_cmd    i_cmd,
    output pfrm_pkg::t_status o_status,
    pfrm_res_if.source        o_res
);

    localparam int AW = pfrm_pkg::ADDR_W;

    logic [7:0] r_mem [pfrm_pkg::DEPTH];
    logic [7:0] r_rdata;

    logic [2:0]    r_offset;
    logic [AW-1:0] r_clr_addr;

    logic       r_req_type;
    logic [7:0] r_xf;
    logic [7:0] r_xs;
    logic [5:0] r_yf;
    logic [6:0] r_ys;
    logic [7:0] r_pix;

    logic [7:0] r_x0;
    logic [7:0] r_xl;
    logic [5:0] r_byf;
    logic [5:0] r_byl;
    logic [2:0] r_page;
    logic [7:0] r_col;
    logic       r_active;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_data;
    logic       r_out_eop;
    logic       r_out_eor;
    logic       r_out_bad;
    logic       r_out_last;

    logic [8:0]    hdr_x0;
    logic [8:0]    hdr_x1;
    logic          hdr_bad;
    logic [AW-1:0] idx;
    logic [6:0]    ys_b;
    logic [7:0]    mask;
    logic [7:0]    merged;
    logic          eop;
    logic          eor;
    logic          out_free;
    logic [7:0]    n_out_byte;
    logic          n_out_data;
    logic          n_out_eop;
    logic          n_out_eor;
    logic          n_out_bad;

    assign hdr_x0  = {1'b0, r_xf} + {6'd0, r_offset};
    assign hdr_x1  = {1'b0, r_xs} + {6'd0, r_offset};
    assign hdr_bad = (r_xf >= r_xs) || ({1'b0, r_yf} >= r_ys)
                  || (hdr_x1 > 9'(pfrm_pkg::COLUMN_COUNT))
                  || ({1'b0, r_ys} > 8'(pfrm_pkg::ROW_COUNT));

    assign idx = AW'(r_page) * AW'(pfrm_pkg::COLUMN_COUNT) + AW'(r_col);

    assign ys_b = {1'b0, r_byl} + 7'd1;

    always_comb begin
        mask = pfrm_pkg::FULL_MASK;
        if (r_page == r_byf[5:3]) begin
            mask = mask & (pfrm_pkg::FULL_MASK << r_byf[2:0]);
        end
        if ((r_page == r_byl[5:3]) && (ys_b[2:0] != 3'd0)) begin
            mask = mask & ((8'd1 << ys_b[2:0]) - 8'd1);
        end
    end

    assign merged = (r_rdata & ~mask) | (r_pix & mask);
    assign eop    = (r_col == r_xl);
    assign eor    = eop && (r_page == r_byl[5:3]);

    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_byte = 8'd0;
        n_out_data = 1'b0;
        n_out_eop  = 1'b0;
        n_out_eor  = 1'b0;
        n_out_bad  = 1'b0;
        case (i_cmd.sel)
            pfrm_pkg::OUT_BAD: begin
                n_out_bad = 1'b1;
            end
            pfrm_pkg::OUT_CMD_LOW: begin
                n_out_byte = r_x0 & pfrm_pkg::NIBBLE;
            end
            pfrm_pkg::OUT_CMD_HIGH: begin
                n_out_byte = pfrm_pkg::CMD_COL_HIGH + ((r_x0 >> 4) & pfrm_pkg::NIBBLE);
            end
            pfrm_pkg::OUT_CMD_PAGE: begin
                n_out_byte = pfrm_pkg::CMD_PAGE_BASE | {5'd0, r_page};
            end
            pfrm_pkg::OUT_DATA: begin
                n_out_byte = merged;
                n_out_data = 1'b1;
                n_out_eop  = eop;
                n_out_eor  = eor;
            end
            default: begin
                n_out_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[idx];
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_cmd.commit) begin
            r_mem[idx] <= merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_xf       <= i_rect_x_first;
            r_xs       <= i_rect_x_stop;
            r_yf       <= i_rect_y_first;
            r_ys       <= i_rect_y_stop;
            r_pix      <= i_pixel_byte;
        end
        if (i_cmd.load) begin
            r_out_byte <= n_out_byte;
            r_out_data <= n_out_data;
            r_out_eop  <= n_out_eop;
            r_out_eor  <= n_out_eor;
            r_out_bad  <= n_out_bad;
            r_out_last <= (i_cmd.sel == pfrm_pkg::OUT_BAD) || (i_cmd.sel == pfrm_pkg::OUT_DATA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= pfrm_pkg::OFFSET_RESET;
            r_clr_addr  <= '0;
            r_x0        <= 8'd0;
            r_xl        <= 8'd0;
            r_byf       <= 6'd0;
            r_byl       <= 6'd0;
            r_page      <= 3'd0;
            r_col       <= 8'd0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.open) begin
                r_x0     <= hdr_x0[7:0];
                r_xl     <= 8'(hdr_x1 - 9'd1);
                r_byf    <= r_yf;
                r_byl    <= 6'(r_ys - 7'd1);
                r_page   <= r_yf[5:3];
                r_col    <= hdr_x0[7:0];
                r_active <= 1'b1;
            end else if (i_cmd.commit) begin
                if (eor) begin
                    r_active <= 1'b0;
                end else if (eop) begin
                    r_page <= r_page + 3'd1;
                    r_col  <= r_x0;
                end else begin
                    r_col <= r_col + 8'd1;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clear_last  = (r_clr_addr == AW'(pfrm_pkg::DEPTH - 1));
    assign o_status.is_hdr      = !r_req_type;
    assign o_status.hdr_bad     = hdr_bad;
    assign o_status.rect_active = r_active;
    assign o_status.first_col   = (r_col == r_x0);
    assign o_status.out_free    = out_free;

    assign o_res.valid        = r_out_valid;
    assign o_res.out_byte     = r_out_byte;
    assign o_res.is_data      = r_out_data;
    assign o_res.end_of_page  = r_out_eop;
    assign o_res.end_of_rect  = r_out_eor;
    assign o_res.bad_rect     = r_out_bad;
    assign o_res.last_of_item = r_out_last;

endmodule

[src/pfrm_ctrl.sv]
`timescale 1ns / 1ps

module pfrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pfrm_pkg::t_status i_status,
    output pfrm_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_BAD,
        S_CMD_LOW,
        S_CMD_HIGH,
        S_CMD_PAGE,
        S_MERGE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.clear   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.open    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.sel     = pfrm_pkg::OUT_BAD;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_hdr) begin
                    if (i_status.hdr_bad) begin
                        n_state = S_BAD;
                    end else begin
                        o_cmd.open = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (!i_status.rect_active) begin
                    n_state = S_IDLE;
                end else if (i_status.first_col) begin
                    n_state = S_CMD_LOW;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_BAD: begin
                o_cmd.sel = pfrm_pkg::OUT_BAD;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CMD_LOW: begin
                o_cmd.sel = pfrm_pkg::OUT_CMD_LOW;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMD_HIGH;
                end
            end
            S_CMD_HIGH: begin
                o_cmd.sel = pfrm_pkg::OUT_CMD_HIGH;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMD_PAGE;
                end
            end
            S_CMD_PAGE: begin
                o_cmd.sel = pfrm_pkg::OUT_CMD_PAGE;
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.sel = pfrm_pkg::OUT_DATA;
                if (i_status.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE) && !(r_state == S_IDLE && i_in_valid && r_ready);
        end
    end

    assign o_in_ready = r_ready;

endmodule

[src/page_framebuffer_rect_merge_core.sv]
`timescale 1ns / 1ps

// Shadow frame store for a page-mode monochrome panel with rectangle merge.
// Requests arrive on i_req: a header opens a rectangle, then one bitmap byte
// per column follows, page by page. Results leave on o_res as panel command
// and display data bytes; each request gives zero to four results, the last
// one flagged by last_of_item. The column offset is written through i_cfg_we
// and i_cfg_wdata; the user must write it only while the block is idle, as
// the block has no check for this. A header is decoded and opens the
// rectangle; a rejected one passes through S_BAD, which loads the bad_rect
// result. A bitmap byte is decoded and merged, and at the first column of a
// page the three command bytes pass before it through the single output
// register, one per cycle while the receiver takes them. i_req.ready stays
// low until the controller is back in idle, so no new request is taken while
// one is in work. The data byte comes from the registered read of the frame
// memory followed by the merge and write-back. After reset the frame memory
// is cleared one byte per cycle, 1056 in all, with i_req.ready held low.
// When the receiver stalls, the result waits in the output register and the
// controller holds until it is taken; no result is dropped.

module page_framebuffer_rect_merge_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    pfrm_req_if.sink    i_req,
    pfrm_res_if.source  o_res
);

    pfrm_pkg::t_cmd    cmd;
    pfrm_pkg::t_status status;
    logic              in_ready;

    assign i_req.ready = in_ready;

    pfrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfrm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req.req_type),
        .i_rect_x_first (i_req.rect_x_first),
        .i_rect_x_stop  (i_req.rect_x_stop),
        .i_rect_y_first (i_req.rect_y_first),
        .i_rect_y_stop  (i_req.rect_y_stop),
        .i_pixel_byte   (i_req.pixel_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_res          (o_res)
    );

endmodule

[tb/tb_page_framebuffer_rect_merge_core.sv]
`timescale 1ns / 1ps

module tb_page_framebuffer_rect_merge_core;

    localparam bit REQ_HEADER = 1'b0;
    localparam bit REQ_PIXELS = 1'b1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       end_of_page;
        logic       end_of_rect;
        logic       bad_rect;
        logic       last_of_item;
    } t_panel_out;

    class t_panel_scoreboard;
        logic [7:0] shadow [pfrm_pkg::DEPTH];
        logic [2:0] page_q;
        logic [7:0] col_q;
        logic [7:0] first_col;
        logic [7:0] last_col;
        logic [5:0] top_row;
        logic [5:0] bottom_row;
        bit         open_rect;
        logic [2:0] offset;
        t_panel_out pending_bytes[$];
        int         mismatches;

        function new();
            foreach (shadow[i]) shadow[i] = 8'h00;
            page_q     = 3'd0;
            col_q      = 8'd0;
            first_col  = 8'd0;
            last_col   = 8'd0;
            top_row    = 6'd0;
            bottom_row = 6'd0;
            open_rect  = 1'b0;
            offset     = pfrm_pkg::OFFSET_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void push(logic [7:0] v, bit d, bit eop, bit eor, bit bad, bit last);
            t_panel_out r;
            r = '{value: v, is_data: d, end_of_page: eop, end_of_rect: eor,
                  bad_rect: bad, last_of_item: last};
            pending_bytes.push_back(r);
        endfunction

        // Returns 1 when the request is a bitmap byte with no rectangle open.
        function bit take_request(bit typ, logic [7:0] xf, logic [7:0] xs,
                                  logic [5:0] yf, logic [6:0] ys, logic [7:0] pix);
            int         x_lo;
            int         x_hi;
            int         addr;
            logic [7:0] mask;
            logic [7:0] merged;
            logic [6:0] stop_row;
            bit         eop;
            bit         eor;
            if (typ == REQ_HEADER) begin
                x_lo = int'(xf) + int'(offset);
                x_hi = int'(xs) + int'(offset);
                if (xf >= xs || yf >= ys || x_hi > pfrm_pkg::COLUMN_COUNT
                    || ys > pfrm_pkg::ROW_COUNT) begin
                    push(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
                    return 1'b0;
                end
                first_col  = x_lo[7:0];
                last_col   = 8'(x_hi - 1);
                top_row    = yf;
                bottom_row = 6'(ys - 7'd1);
                page_q     = yf[5:3];
                col_q      = x_lo[7:0];
                open_rect  = 1'b1;
                return 1'b0;
            end
            if (!open_rect) return 1'b1;
            if (col_q == first_col) begin
                push({4'h0, first_col[3:0]}, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                push(pfrm_pkg::CMD_COL_HIGH + {4'h0, first_col[7:4]},
                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                push(pfrm_pkg::CMD_PAGE_BASE | {5'd0, page_q}, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            mask = pfrm_pkg::FULL_MASK;
            if (page_q == top_row[5:3]) mask = mask & (pfrm_pkg::FULL_MASK << top_row[2:0]);
            stop_row = {1'b0, bottom_row} + 7'd1;
            if (page_q == bottom_row[5:3] && stop_row[2:0] != 3'd0)
                mask = mask & ((8'd1 << stop_row[2:0]) - 8'd1);
            addr = int'(page_q) * pfrm_pkg::COLUMN_COUNT + int'(col_q);
            merged = (shadow[addr] & ~mask) | (pix & mask);
            shadow[addr] = merged;
            eop = (col_q == last_col);
            eor = eop && (page_q == bottom_row[5:3]);
            push(merged, 1'b1, eop, eor, 1'b0, 1'b1);
            if (eor) begin
                open_rect = 1'b0;
            end else if (eop) begin
                page_q = page_q + 3'd1;
                col_q  = first_col;
            end else begin
                col_q = col_q + 8'd1;
            end
            return 1'b0;
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        endfunction

        function void match_output(t_panel_out got);
            t_panel_out want;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected nothing, got %0h", $time, got);
                return;
            end
            want = pending_bytes.pop_front();
            if (got.value !== want.value) report("out_byte", want.value, got.value);
            if (got.is_data !== want.is_data) report("is_data", want.is_data, got.is_data);
            if (got.end_of_page !== want.end_of_page)
                report("end_of_page", want.end_of_page, got.end_of_page);
            if (got.end_of_rect !== want.end_of_rect)
                report("end_of_rect", want.end_of_rect, got.end_of_rect);
            if (got.bad_rect !== want.bad_rect) report("bad_rect", want.bad_rect, got.bad_rect);
            if (got.last_of_item !== want.last_of_item)
                report("last_of_item", want.last_of_item, got.last_of_item);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;

    pfrm_req_if req_bus ();
    pfrm_res_if res_bus ();

    page_framebuffer_rect_merge_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    t_panel_scoreboard model = new();
    int items_taken = 0;
    int cycles = 0;
    bit no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The receiver alternates runs of readiness with stalls of random length.
    initial begin
        int run;
        int stall;
        res_bus.ready = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            stall = pick_gap();
            @(negedge i_clk);
            res_bus.ready = 1'b1;
            repeat (run - 1) @(negedge i_clk);
            if (stall > 0) begin
                @(negedge i_clk);
                res_bus.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            model.match_output('{value: res_bus.out_byte, is_data: res_bus.is_data,
                                 end_of_page: res_bus.end_of_page,
                                 end_of_rect: res_bus.end_of_rect,
                                 bad_rect: res_bus.bad_rect,
                                 last_of_item: res_bus.last_of_item});
    end

    task automatic send_req(bit typ, logic [7:0] xf, logic [7:0] xs, logic [5:0] yf,
                            logic [6:0] ys, logic [7:0] pix);
        int gap;
        @(negedge i_clk);
        req_bus.valid        = 1'b1;
        req_bus.req_type     = typ;
        req_bus.rect_x_first = xf;
        req_bus.rect_x_stop  = xs;
        req_bus.rect_y_first = yf;
        req_bus.rect_y_stop  = ys;
        req_bus.pixel_byte   = pix;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        if (!model.take_request(typ, xf, xs, yf, ys, pix)) items_taken++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_header(int xf, int xs, int yf, int ys);
        send_req(REQ_HEADER, 8'(xf), 8'(xs), 6'(yf), 7'(ys), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_pixels(int pix);
        send_req(REQ_PIXELS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)), 8'(pix));
    endtask

    // Lowers valid and lets the block drain before the column offset may change.
    task automatic drain();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [2:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        model.offset = v;
    endtask

    // Mostly complete rectangles with random content, the rest broken sequences
    // and stray requests.
    task automatic run_phase(int n);
        int target;
        int r;
        int w;
        int xf;
        int yf;
        int ys;
        int ys_max;
        int total;
        int stop_at;
        target = items_taken + n;
        while (items_taken < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
                if ($urandom_range(0, 1) == 1)
                    xf = $urandom_range(0, 12);
                else
                    xf = $urandom_range(0, pfrm_pkg::COLUMN_COUNT - int'(model.offset) - w);
                yf = $urandom_range(0, pfrm_pkg::ROW_COUNT - 1);
                ys_max = (yf + 17 < pfrm_pkg::ROW_COUNT) ? yf + 17 : pfrm_pkg::ROW_COUNT;
                ys = $urandom_range(yf + 1, ys_max);
                total = w * (((ys - 1) >> 3) - (yf >> 3) + 1);
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
                send_header(xf, xf + w, yf, ys);
                for (int k = 0; k < stop_at; k++) send_pixels($urandom_range(0, 255));
            end else if (r < 88) begin
                send_header($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 63), $urandom_range(0, 127));
            end else begin
                send_pixels($urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = 3'd0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_HEADER;
        req_bus.rect_x_first = 8'd0;
        req_bus.rect_x_stop  = 8'd0;
        req_bus.rect_y_first = 6'd0;
        req_bus.rect_y_stop  = 7'd0;
        req_bus.pixel_byte   = 8'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests under the reset value of the column offset.
        send_pixels(8'hFF);
        send_header(5, 5, 0, 8);
        send_header(0, 4, 10, 10);
        send_header(0, 131, 0, 8);
        send_header(0, 4, 0, 65);
        send_header(0, 2, 3, 13);
        send_pixels(8'hFF);
        send_pixels(8'h00);
        send_pixels(8'hA5);
        send_pixels(8'h5A);
        send_header(129, 130, 56, 64);
        send_pixels(8'hFF);
        send_header(10, 13, 63, 64);
        send_pixels(8'hFF);
        send_pixels(8'h7F);
        send_header(200, 100, 0, 8);
        send_pixels(8'hFF);
        send_header(20, 24, 8, 24);
        send_pixels(8'h3C);
        send_pixels(8'h3C);
        send_header(20, 21, 9, 10);
        send_pixels(8'hFF);
        send_pixels(8'h12);
        send_header(255, 255, 63, 127);

        drain();
        write_offset(3'd0);
        run_phase(44);
        drain();
        write_offset(3'd7);
        run_phase(44);
        drain();
        write_offset(3'd4);
        no_idle = 1'b1;
        run_phase(40);
        no_idle = 1'b0;
        drain();
        write_offset(3'd5);
        run_phase(44);
        drain();
        write_offset(3'd1);
        run_phase(44);
        drain();
        write_offset(3'd3);
        run_phase(44);
        drain();

        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
src/pfrm_pkg.sv
src/pfrm_if.sv
src/pfrm_datapath.sv
src/pfrm_ctrl.sv
src/page_framebuffer_rect_merge_core.sv
tb/tb_page_framebuffer_rect_merge_core.sv
